FILE: rtl/tcpip_pkg.sv
package tcpip_pkg;

  localparam int REQ_W    = 2;
  localparam int VERT_W   = 13;
  localparam int TILE_W   = 10;
  localparam int IN_DW    = 48;
  localparam int OUT_DW   = 8;
  localparam int PROD_W   = 28;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  typedef struct packed {
    logic take;
    logic corner_start;
    logic ld_j;
    logic ld_i;
    logic mul2;
    logic div_load;
    logic div_step;
    logic cmp;
    logic edge_next;
    logic corner_next;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic straddle;
    logic last_edge;
    logic div_last;
    logic odd;
    logic last_corner;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/tcpip_dp.sv
module tcpip_dp #(
  parameter int MAX_VERTS  = 256,
  parameter int TILE_SCALE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcpip_pkg::cmd_t                 cmd,
  output tcpip_pkg::sts_t                 sts,
  input  logic [tcpip_pkg::REQ_W-1:0]     in_req,
  input  logic [tcpip_pkg::IN_DW-1:0]     in_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tcpip_pkg::OUT_DW-1:0]    out_tdata
);
  import tcpip_pkg::*;

  localparam int AW    = $clog2(MAX_VERTS);
  localparam int CNTW  = $clog2(MAX_VERTS + 1);
  localparam int SW    = $clog2(TILE_SCALE + 1);
  localparam int NW    = PROD_W + SW + 1;
  localparam int DCW   = $clog2(NW + 1);
  localparam logic signed [SW:0] SCALE_S = (SW+1)'(TILE_SCALE);

  logic [VERT_W-1:0] mem_x [MAX_VERTS];
  logic [VERT_W-1:0] mem_y [MAX_VERTS];
  logic [VERT_W-1:0] rd_x_r, rd_y_r;
  logic [AW-1:0]     rd_addr;

  logic [CNTW-1:0]   cnt_r;
  logic              drop_r;
  logic [TILE_W-1:0] tx_r, ty_r;
  logic [1:0]        corner_r;
  logic [AW-1:0]     i_r;
  logic [VERT_W-1:0] xj_r, yj_r, xi_r, yi_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [NW-1:0]     num_r;
  logic              odd_r;
  logic [VERT_W:0]   rem_r;
  logic [NW-1:0]     quo_r;
  logic [VERT_W-1:0] den_r;
  logic              neg_r;
  logic [DCW-1:0]    dcnt_r;
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  logic [TILE_W:0]   px, py;
  logic [VERT_W-1:0] py_ext;
  logic signed [VERT_W:0]   a_s, b_s, d_s, pd_s;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [NW-1:0]     num_c;
  logic [NW-1:0]            num_mag;
  logic [VERT_W:0]          trial;
  logic signed [NW:0]       q_s, p_s;
  logic                     full;
  logic [VERT_W-1:0]        in_vx, in_vy;
  logic [TILE_W-1:0]        in_tx, in_ty;

  assign in_vx = in_data[VERT_W-1:0];
  assign in_vy = in_data[2*VERT_W-1:VERT_W];
  assign in_tx = in_data[2*VERT_W+TILE_W-1:2*VERT_W];
  assign in_ty = in_data[2*VERT_W+2*TILE_W-1:2*VERT_W+TILE_W];

  assign full   = (cnt_r == CNTW'(MAX_VERTS));
  assign px     = {1'b0, tx_r} + (TILE_W+1)'(corner_r[1]);
  assign py     = {1'b0, ty_r} + (TILE_W+1)'(corner_r[0]);
  assign py_ext = VERT_W'(py);

  always_comb begin
    if (cmd.corner_start) begin
      rd_addr = AW'(cnt_r - CNTW'(1));
    end else if (cmd.edge_next) begin
      rd_addr = i_r + AW'(1);
    end else begin
      rd_addr = i_r;
    end
  end

  // Edge terms: vertex i comes from the read register, but d_s uses yi_r.
  assign a_s    = $signed({1'b0, xj_r}) - $signed({1'b0, rd_x_r});
  assign b_s    = $signed({1'b0, py_ext}) - $signed({1'b0, rd_y_r});
  assign d_s    = $signed({1'b0, yj_r}) - $signed({1'b0, yi_r});
  assign prod_c = a_s * b_s;
  assign num_c  = NW'(prod_r) * NW'(SCALE_S);
  assign num_mag = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
  assign trial  = {rem_r[VERT_W-1:0], quo_r[NW-1]} - {1'b0, den_r};

  // Both sides of the crossing test are scaled up by one factor of the scale.
  assign q_s  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign pd_s = $signed({3'b0, px}) - $signed({1'b0, xi_r});
  assign p_s  = (NW+1)'(pd_s) * (NW+1)'(SCALE_S);

  always_ff @(posedge clk) begin
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
    if (cmd.take && in_req == REQ_APPEND && !full) begin
      mem_x[AW'(cnt_r)] <= in_vx;
      mem_y[AW'(cnt_r)] <= in_vy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      odd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        unique case (in_req)
          REQ_CLEAR: begin
            cnt_r  <= '0;
            drop_r <= 1'b0;
          end
          REQ_APPEND: begin
            if (full) begin
              drop_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + CNTW'(1);
            end
          end
          REQ_QUERY: odd_r <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.corner_start) begin
        odd_r <= 1'b0;
      end else if (cmd.cmp && (p_s < q_s)) begin
        odd_r <= !odd_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      tx_r     <= in_tx;
      ty_r     <= in_ty;
      corner_r <= 2'd0;
    end
    if (cmd.corner_next) begin
      corner_r <= corner_r + 2'd1;
    end
    if (cmd.corner_start) begin
      i_r <= '0;
    end
    if (cmd.ld_j) begin
      xj_r <= rd_x_r;
      yj_r <= rd_y_r;
    end
    if (cmd.ld_i) begin
      xi_r   <= rd_x_r;
      yi_r   <= rd_y_r;
      prod_r <= prod_c;
    end
    if (cmd.mul2) begin
      num_r <= num_c;
    end
    if (cmd.div_load) begin
      quo_r  <= num_mag;
      rem_r  <= '0;
      den_r  <= d_s[VERT_W] ? VERT_W'(-d_s) : VERT_W'(d_s);
      neg_r  <= num_r[NW-1] ^ d_s[VERT_W];
      dcnt_r <= DCW'(NW);
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DCW'(1);
      if (!trial[VERT_W]) begin
        rem_r <= trial;
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[VERT_W-1:0], quo_r[NW-1]};
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
    end
    if (cmd.edge_next) begin
      xj_r <= xi_r;
      yj_r <= yi_r;
      i_r  <= i_r + AW'(1);
    end
    if (cmd.out_load) begin
      out_data_r <= {(OUT_DW-2)'(0), drop_r, odd_r};
    end
  end

  assign sts.empty       = (cnt_r == '0);
  assign sts.straddle    = (rd_y_r > py_ext) ^ (yj_r > py_ext);
  assign sts.last_edge   = (CNTW'(i_r) + CNTW'(1) == cnt_r);
  assign sts.div_last    = (dcnt_r == DCW'(1));
  assign sts.odd         = odd_r;
  assign sts.last_corner = (corner_r == 2'd3);
  assign sts.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/tcpip_ctrl.sv
module tcpip_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tcpip_pkg::REQ_W-1:0] in_req,
  input  tcpip_pkg::sts_t             sts,
  output tcpip_pkg::cmd_t             cmd
);
  import tcpip_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'h001,
    S_CSTART = 11'h002,
    S_JRD    = 11'h004,
    S_EVAL   = 11'h008,
    S_MUL2   = 11'h010,
    S_DIVLD  = 11'h020,
    S_DIV    = 11'h040,
    S_CMP    = 11'h080,
    S_NEXT   = 11'h100,
    S_CEND   = 11'h200,
    S_DONE   = 11'h400
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (in_req == REQ_QUERY) begin
            state_nxt = S_CSTART;
          end
        end
      end
      S_CSTART: begin
        cmd.corner_start = 1'b1;
        state_nxt = sts.empty ? S_CEND : S_JRD;
      end
      S_JRD: begin
        cmd.ld_j  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.ld_i  = 1'b1;
        state_nxt = sts.straddle ? S_MUL2 : S_NEXT;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.edge_next = 1'b1;
        state_nxt = sts.last_edge ? S_CEND : S_EVAL;
      end
      S_CEND: begin
        if (sts.odd || sts.last_corner) begin
          state_nxt = S_DONE;
        end else begin
          cmd.corner_next = 1'b1;
          state_nxt = S_CSTART;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/tile_corner_point_in_polygon_top.sv
// Channel  Direction  tdata / tuser
// in_      slave      tuser: req_type; tdata: vertex_x, vertex_y, tile_x, tile_y
// out_     master     tdata: inside_res, overflowed
//
// Clear and append complete on acceptance in the idle state. A query is accepted;
// each corner tried starts (S_CSTART), reads its closing vertex (S_JRD) and
// evaluates and steps each edge (S_EVAL, S_NEXT), which an empty polygon skips;
// an edge straddling the corner's row adds S_MUL2, S_DIVLD, S_DIV and S_CMP; the
// result is loaded last. The serial restoring divider sets one quotient bit per
// cycle. Corners stop at the first hit. Reset (rst_n, synchronous) empties the
// polygon. A pending result sits in the output register; a following query runs
// and then waits for it, holding off further input.
module tile_corner_point_in_polygon_top #(
  parameter int MAX_VERTS  = 256,
  parameter int TILE_SCALE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [12:0] vertex_x, [25:13] vertex_y, [35:26] tile_x, [45:36] tile_y
  input  logic [47:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] inside_res, [1] overflowed
  output logic [7:0]  out_tdata
);
  import tcpip_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcpip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcpip_dp #(
    .MAX_VERTS  (MAX_VERTS),
    .TILE_SCALE (TILE_SCALE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req     (in_tuser),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
